// ----- rtl/assert_macros.svh -----
// Assertion shorthands, all clocked on clk and held off while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every edge.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/gsds_pkg.sv -----
`default_nettype none

package gsds_pkg;

  localparam int OCC_W  = 16;
  localparam int STEP_W = 5;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  typedef logic [CFG_IDX_W-1:0] cfg_index_t;
  localparam cfg_index_t CFG_START_VALUE = 2'd0;
  localparam cfg_index_t CFG_STOP_VALUE  = 2'd1;
  localparam cfg_index_t CFG_TARGET_OCC  = 2'd2;

  // input word modes
  localparam logic MODE_START   = 1'b0;
  localparam logic MODE_MEASURE = 1'b1;

  // golden-section fractions, Q0.16, truncated
  localparam logic [OCC_W-1:0] GOLD_LOW_Q16  = 16'd25032;
  localparam logic [OCC_W-1:0] GOLD_HIGH_Q16 = 16'd40503;

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;

  typedef struct packed {
    logic             is_start;
    logic [OCC_W-1:0] occupancy;
  } q_word_t;

endpackage

`default_nettype wire

// ----- rtl/gsds_in_if.sv -----
`default_nettype none

interface gsds_in_if;
  import gsds_pkg::*;

  logic             valid;
  logic             ready;
  logic             mode;
  logic [OCC_W-1:0] occupancy;

  modport source (output valid, output mode, output occupancy, input ready);
  modport sink (input valid, input mode, input occupancy, output ready);

endinterface

`default_nettype wire

// ----- rtl/gsds_out_if.sv -----
`default_nettype none

interface gsds_out_if #(
  parameter int DAC_WIDTH = 10
);

  logic                 valid;
  logic                 ready;
  logic [DAC_WIDTH-1:0] dac_value;
  logic                 is_final;
  logic                 search_active;

  modport source (output valid, output dac_value, output is_final, output search_active,
                  input ready);
  modport sink (input valid, input dac_value, input is_final, input search_active,
                output ready);

endinterface

`default_nettype wire

// ----- rtl/gsds_front.sv -----
`default_nettype none

module gsds_front
  import gsds_pkg::*;
#(
  parameter int DAC_WIDTH = 10,
  localparam int CFG_W = (DAC_WIDTH > OCC_W) ? DAC_WIDTH : OCC_W
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // configuration
  input  wire logic                 cfg_we,
  input  wire cfg_index_t           cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  // input words
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 in_mode,
  input  wire logic [OCC_W-1:0]     in_occupancy,
  // queue write side
  output logic                      q_push,
  output q_word_t                   q_word,
  input  wire logic                 q_full,
  // window set-up for the back end
  output logic [DAC_WIDTH-1:0]      win_start,
  output logic [DAC_WIDTH:0]        win_end,
  output logic [STEP_W-1:0]         step_limit,
  output logic [OCC_W-1:0]          target
);

  logic [DAC_WIDTH-1:0] start_value;
  logic [DAC_WIDTH-1:0] stop_value;
  logic [OCC_W-1:0]     target_occupancy;
  logic [DAC_WIDTH-1:0] stop_clamped;
  logic [DAC_WIDTH:0]   win_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_value      <= '0;
      stop_value       <= '1;
      target_occupancy <= '1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_START_VALUE: start_value      <= cfg_data[DAC_WIDTH-1:0];
        CFG_STOP_VALUE:  stop_value       <= cfg_data[DAC_WIDTH-1:0];
        CFG_TARGET_OCC:  target_occupancy <= cfg_data[OCC_W-1:0];
        default: ;
      endcase
    end
  end

  // stop below start collapses the window to one value
  assign stop_clamped = (stop_value < start_value) ? start_value : stop_value;
  assign win_start    = start_value;
  assign win_end      = {1'b0, stop_clamped} + {{DAC_WIDTH{1'b0}}, 1'b1};
  assign win_count    = win_end - {1'b0, start_value};
  assign target       = target_occupancy;

  // step limit is the bit length of the window size
  always_comb begin
    step_limit = '0;
    for (int i = 0; i <= DAC_WIDTH; i++) begin
      if (win_count[i]) step_limit = STEP_W'(i + 1);
    end
  end

  assign in_ready           = !q_full;
  assign q_push             = in_valid && !q_full;
  assign q_word.is_start    = (in_mode == MODE_START);
  assign q_word.occupancy   = in_occupancy;

endmodule

`default_nettype wire

// ----- rtl/gsds_queue.sv -----
`default_nettype none

module gsds_queue
  import gsds_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire q_word_t push_word,
  output logic         full,
  input  wire logic    pop,
  output logic         valid,
  output q_word_t      head
);

  q_word_t           slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full  = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign valid = (count != '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/gsds_back.sv -----
`default_nettype none

module gsds_back
  import gsds_pkg::*;
#(
  parameter int DAC_WIDTH = 10
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // queue read side
  input  wire logic                 q_valid,
  input  wire q_word_t              q_head,
  output logic                      q_pop,
  // window set-up
  input  wire logic [DAC_WIDTH-1:0] win_start,
  input  wire logic [DAC_WIDTH:0]   win_end,
  input  wire logic [STEP_W-1:0]    step_limit,
  input  wire logic [OCC_W-1:0]     target,
  // result words
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [DAC_WIDTH-1:0]      out_dac_value,
  output logic                      out_is_final,
  output logic                      out_search_active
);

  localparam int PROD_W = DAC_WIDTH + 1 + OCC_W;

  logic [DAC_WIDTH:0]   window_low, window_high;
  logic [DAC_WIDTH-1:0] probe_low, probe_high;
  logic [OCC_W-1:0]     occ_low, occ_high;
  logic                 direction_high;
  logic [STEP_W-1:0]    step_index, step_lim;
  logic [DAC_WIDTH-1:0] last_probe;
  logic                 active;

  logic [DAC_WIDTH:0]   window_low_next, window_high_next;
  logic [DAC_WIDTH-1:0] probe_low_next, probe_high_next;
  logic [OCC_W-1:0]     occ_low_next, occ_high_next;
  logic                 direction_high_next;
  logic [STEP_W-1:0]    step_index_next, step_lim_next;
  logic [DAC_WIDTH-1:0] last_probe_next;
  logic                 active_next;
  logic                 do_probe, final_flag;

  logic [OCC_W-1:0]     vl, vh, dl, dh;
  logic                 last_step;
  logic [DAC_WIDTH:0]   span, probe_sum;
  logic [OCC_W-1:0]     gold;
  logic [PROD_W-1:0]    prod;
  logic [DAC_WIDTH-1:0] probe;

  assign q_pop = q_valid && (!out_valid || out_ready);

  // occupancies with the current measurement recorded
  assign vl = direction_high ? occ_low : q_head.occupancy;
  assign vh = direction_high ? q_head.occupancy : occ_high;
  assign dl = (vl > target) ? vl - target : target - vl;
  assign dh = (vh > target) ? vh - target : target - vh;
  assign last_step = ({1'b0, step_index} >= ({1'b0, step_lim} + 1'b1));

  always_comb begin
    window_low_next     = window_low;
    window_high_next    = window_high;
    probe_low_next      = probe_low;
    probe_high_next     = probe_high;
    occ_low_next        = occ_low;
    occ_high_next       = occ_high;
    direction_high_next = direction_high;
    step_index_next     = step_index;
    step_lim_next       = step_lim;
    last_probe_next     = last_probe;
    active_next         = active;
    do_probe            = 1'b0;
    final_flag          = 1'b0;
    if (q_head.is_start) begin
      window_low_next     = {1'b0, win_start};
      window_high_next    = win_end;
      direction_high_next = 1'b0;
      step_index_next     = '0;
      step_lim_next       = step_limit;
      active_next         = 1'b1;
      do_probe            = 1'b1;
    end else if (active) begin
      occ_low_next  = vl;
      occ_high_next = vh;
      if (step_index == '0) begin
        direction_high_next = 1'b1;
        step_index_next     = STEP_W'(1);
        do_probe            = 1'b1;
      end else if (last_step) begin
        // nearer probe wins; a tie keeps the last one
        if (dl < dh) begin
          last_probe_next = probe_low;
        end else if (dh < dl) begin
          last_probe_next = probe_high;
        end
        final_flag  = 1'b1;
        active_next = 1'b0;
      end else begin
        if (vh > target) begin
          window_low_next = {1'b0, probe_high};
        end else if (vl < vh || vl > target) begin
          window_low_next = {1'b0, probe_low};
        end
        if (vl >= vh && vh < target) window_high_next = {1'b0, probe_high};
        if (vl < vh || vh > target) begin
          probe_low_next = probe_high;
          occ_low_next   = vh;
        end
        if (vl >= vh && vl < target) begin
          probe_high_next     = probe_low;
          occ_high_next       = vl;
          direction_high_next = 1'b0;
        end else begin
          direction_high_next = 1'b1;
        end
        step_index_next = step_index + 1'b1;
        do_probe        = 1'b1;
      end
    end
  end

  // probe from the updated window and direction
  assign span = (window_high_next > window_low_next) ? window_high_next - window_low_next
                                                     : '0;
  assign gold = direction_high_next ? GOLD_HIGH_Q16 : GOLD_LOW_Q16;
  assign prod = {{OCC_W{1'b0}}, span} * {{(DAC_WIDTH + 1){1'b0}}, gold};
  assign probe_sum = window_low_next + prod[PROD_W-1:OCC_W];
  assign probe = probe_sum[DAC_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      window_low        <= '0;
      window_high       <= '0;
      probe_low         <= '0;
      probe_high        <= '0;
      occ_low           <= '0;
      occ_high          <= '0;
      direction_high    <= 1'b0;
      step_index        <= '0;
      step_lim          <= '0;
      last_probe        <= '0;
      active            <= 1'b0;
      out_valid         <= 1'b0;
      out_dac_value     <= '0;
      out_is_final      <= 1'b0;
      out_search_active <= 1'b0;
    end else if (q_pop) begin
      window_low        <= window_low_next;
      window_high       <= window_high_next;
      occ_low           <= occ_low_next;
      occ_high          <= occ_high_next;
      direction_high    <= direction_high_next;
      step_index        <= step_index_next;
      step_lim          <= step_lim_next;
      active            <= active_next;
      probe_low         <= (do_probe && !direction_high_next) ? probe : probe_low_next;
      probe_high        <= (do_probe && direction_high_next) ? probe : probe_high_next;
      last_probe        <= do_probe ? probe : last_probe_next;
      out_valid         <= 1'b1;
      out_dac_value     <= do_probe ? probe : last_probe_next;
      out_is_final      <= final_flag;
      out_search_active <= active_next;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/golden_section_dac_search_unit.sv -----
// Golden-section threshold DAC search.
// Channels: in_ch carries mode and occupancy words, out_ch carries dac_value,
// is_final and search_active words, both valid/ready. A mode-0 word opens a
// new search over [start_value, stop_value] and returns the first probe; each
// mode-1 word reports the occupancy measured at the last probe and returns the
// next probe, or the chosen value with is_final set once the step limit passes.
// Exactly one result word per input word, in order.
// Configuration: cfg_we/cfg_index/cfg_data write start_value (0), stop_value (1)
// and target_occupancy (2); write only while no search word is in flight.
// An accepted word is stored in a queue slot and its result then in the output
// register. Throughput: one word per clock while out_ch is not stalled; each
// word takes one pass through the step datapath, whose one constant multiplier
// sets the path length.
// Reset clears the search state and the queue and drops out_ch.valid; the
// registers return to start 0, stop all ones, target all ones.
// A stalled receiver holds the result word; two more words queue up behind it,
// then in_ch.ready falls until the output is taken.
`default_nettype none

module golden_section_dac_search_unit
  import gsds_pkg::*;
#(
  parameter int DAC_WIDTH = 10,
  localparam int CFG_W = (DAC_WIDTH > OCC_W) ? DAC_WIDTH : OCC_W
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire cfg_index_t       cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data,
  gsds_in_if.sink               in_ch,
  gsds_out_if.source            out_ch
);

  logic                 q_push, q_full, q_pop, q_valid;
  q_word_t              q_word, q_head;
  logic [DAC_WIDTH-1:0] win_start;
  logic [DAC_WIDTH:0]   win_end;
  logic [STEP_W-1:0]    step_limit;
  logic [OCC_W-1:0]     target;
  logic                 in_ready;
  logic                 out_valid, out_is_final, out_search_active;
  logic [DAC_WIDTH-1:0] out_dac_value;

  gsds_front #(.DAC_WIDTH(DAC_WIDTH)) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ready),
    .in_mode      (in_ch.mode),
    .in_occupancy (in_ch.occupancy),
    .q_push       (q_push),
    .q_word       (q_word),
    .q_full       (q_full),
    .win_start    (win_start),
    .win_end      (win_end),
    .step_limit   (step_limit),
    .target       (target)
  );

  gsds_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_word (q_word),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  gsds_back #(.DAC_WIDTH(DAC_WIDTH)) u_back (
    .clk               (clk),
    .rst               (rst),
    .q_valid           (q_valid),
    .q_head            (q_head),
    .q_pop             (q_pop),
    .win_start         (win_start),
    .win_end           (win_end),
    .step_limit        (step_limit),
    .target            (target),
    .out_valid         (out_valid),
    .out_ready         (out_ch.ready),
    .out_dac_value     (out_dac_value),
    .out_is_final      (out_is_final),
    .out_search_active (out_search_active)
  );

  assign in_ch.ready          = in_ready;
  assign out_ch.valid         = out_valid;
  assign out_ch.dac_value     = out_dac_value;
  assign out_ch.is_final      = out_is_final;
  assign out_ch.search_active = out_search_active;

endmodule

`default_nettype wire

// ----- rtl/gsds_checker.sv -----
`default_nettype none
`include "assert_macros.svh"

module gsds_checker #(
  parameter int DAC_WIDTH = 10
) (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 in_valid,
  input wire logic                 in_ready,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire logic [DAC_WIDTH-1:0] dac_value,
  input wire logic                 is_final,
  input wire logic                 search_active
);

  logic       in_acc, out_acc;
  logic [2:0] pending;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // words accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + {2'b00, in_acc} - {2'b00, out_acc};
    end
  end

  `ASSERT_IMPL(a_quiet_after_reset, $past(rst), !out_valid, "result word right after reset")
  `ASSERT_IMPL(a_no_orphan_word, out_valid, pending != 3'd0, "result word with nothing in flight")
  `ASSERT_ALWAYS(a_pending_bound, pending <= 3'd3, "more words in flight than storage")
  `ASSERT_IMPL(a_final_ends_search, out_valid && is_final, !search_active, "final word still active")
  `ASSERT_NEXT(a_hold_on_stall, out_valid && !out_ready, out_valid && $stable(dac_value) && $stable(is_final) && $stable(search_active), "stalled result word changed")

endmodule

bind golden_section_dac_search_unit gsds_checker #(.DAC_WIDTH(DAC_WIDTH)) u_gsds_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .dac_value     (out_ch.dac_value),
  .is_final      (out_ch.is_final),
  .search_active (out_ch.search_active)
);

`default_nettype wire
